// ----- sv/planar_odometry_integrator_core_defines.svh -----
// assertion macros shared by the odometry integrator
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define POI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odometry integrator: same-cycle check failed");

// next-cycle implication
`define POI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odometry integrator: next-cycle check failed");

`else

`define POI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define POI_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/poi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

  // item field widths
  localparam int VEL_W  = 16;
  localparam int DT_W   = 16;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;
  localparam int Q_W    = 16;

  // cordic sizing
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IDX_W         = $clog2(ATAN_ENTRIES);
  localparam int CW            = 34;
  localparam int ANG_W         = 32;
  localparam int ATAN_W        = 30;

  localparam logic [IDX_W-1:0] CORDIC_LAST = IDX_W'(CORDIC_ITERS - 1);

  // gain-compensated start vector, Q2.30
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i in 2^32 units per turn
  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  // shared multiplier operand widths
  localparam int A_W   = 33;
  localparam int B_W   = 32;
  localparam int MUL_W = A_W + B_W;

  // radians to 2^32 turn units
  localparam logic signed [B_W-1:0] RAD_TO_TURN = 32'sd683565276;

  // multiply sequence steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_VXC  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_VYS  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_VXS  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_VYC  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RXDT = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RYDT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_WZDT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WZK  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
    logic        [DT_W-1:0]  elapsed;
  } vel_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic        [HEAD_W-1:0] heading;
    logic signed [Q_W-1:0]   quat_z;
    logic signed [Q_W-1:0]   quat_w;
  } pose_t;

  typedef struct packed {
    logic              load_in;
    logic              cor_start;
    logic              cor_sel_new;
    logic              mul_en;
    logic [STEP_W-1:0] mul_step;
    logic              post_en;
    logic [STEP_W-1:0] post_step;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic cor_done;
    logic cor_busy;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/poi_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// velocity item channel
interface poi_vel_if;
  import poi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] yaw_rate;
  logic        [DT_W-1:0]  elapsed;

  modport source (output valid, vel_x, vel_y, yaw_rate, elapsed, input ready);
  modport sink (input valid, vel_x, vel_y, yaw_rate, elapsed, output ready);
endinterface

// pose item channel
interface poi_pose_if;
  import poi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic        [HEAD_W-1:0] heading;
  logic signed [Q_W-1:0]    quat_z;
  logic signed [Q_W-1:0]    quat_w;

  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
  modport sink (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

`default_nettype wire

// ----- sv/poi_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module poi_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [poi_pkg::ANG_W-1:0]     angle,
  output logic                               busy,
  output logic                               done,
  output logic signed [poi_pkg::Q_W-1:0]     sin_q14,
  output logic signed [poi_pkg::Q_W-1:0]     cos_q14
);
  import poi_pkg::*;

  localparam logic signed [CW-1:0] QUARTER   = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF      = 34'sd2147483648;
  localparam logic signed [CW-1:0] ROUND_Q14 = 34'sd32768;
  localparam logic signed [CW-1:0] Q14_ONE   = 34'sd16384;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic                 flip;
  logic [IDX_W-1:0]     idx;

  logic signed [CW-1:0] z_ext;
  logic signed [CW-1:0] z_init;
  logic                 flip_init;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;
  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic signed [CW-1:0] z_next;
  logic signed [CW-1:0] x_fin;
  logic signed [CW-1:0] y_fin;

  // Q2.30 to Q1.14 with rounding and clamp
  function automatic logic signed [Q_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + ROUND_Q14) >>> 16;
    if (r > Q14_ONE) begin
      return Q_W'(Q14_ONE);
    end else if (r < -Q14_ONE) begin
      return Q_W'(-Q14_ONE);
    end else begin
      return r[Q_W-1:0];
    end
  endfunction

  // fold the angle into plus or minus a quarter turn
  always_comb begin
    z_ext = CW'(signed'(angle));
    priority if (z_ext > QUARTER) begin
      z_init    = z_ext - HALF;
      flip_init = 1'b1;
    end else if (z_ext < -QUARTER) begin
      z_init    = z_ext + HALF;
      flip_init = 1'b1;
    end else begin
      z_init    = z_ext;
      flip_init = 1'b0;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = CW'(ATAN_TABLE[idx]);
    if (!z[CW-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        if (idx == CORDIC_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // vector and residual angle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= z_init;
      flip <= flip_init;
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  // undo the half-turn fold and scale down
  always_comb begin
    x_fin   = flip ? -x : x;
    y_fin   = flip ? -y : y;
    cos_q14 = to_q14(x_fin);
    sin_q14 = to_q14(y_fin);
  end

endmodule

`default_nettype wire

// ----- sv/poi_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module poi_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire poi_pkg::vel_t  vel_item,
  input  wire poi_pkg::cmd_t  cmd,
  output poi_pkg::stat_t      stat,
  output poi_pkg::pose_t      pose_item
);
  import poi_pkg::*;

  localparam logic signed [MUL_W-1:0] ROUND_POS  = MUL_W'(65'sd33554432);
  localparam logic signed [MUL_W-1:0] ROUND_HEAD = MUL_W'(65'sd8796093022208);
  localparam logic signed [POS_W+7:0] POS_MAX    = 40'sd2147483647;
  localparam logic signed [POS_W+7:0] POS_MIN    = -40'sd2147483648;

  // latched item
  logic signed [VEL_W-1:0] vx;
  logic signed [VEL_W-1:0] vy;
  logic signed [VEL_W-1:0] wz;
  logic        [DT_W-1:0]  dt;

  // working registers
  logic signed [MUL_W-1:0] prod;
  logic signed [POS_W-1:0] tmp;
  logic signed [POS_W-1:0] rx;
  logic signed [POS_W-1:0] ry;

  // pose state
  logic signed [POS_W-1:0] acc_x;
  logic signed [POS_W-1:0] acc_y;
  logic [HEAD_W-1:0]       heading;

  logic [ANG_W-1:0]        cor_angle;
  logic signed [Q_W-1:0]   sin_q14;
  logic signed [Q_W-1:0]   cos_q14;
  logic                    cor_busy;
  logic                    cor_done;

  logic signed [A_W-1:0]   op_a;
  logic signed [B_W-1:0]   op_b;
  logic signed [MUL_W-1:0] prod_next;
  logic signed [MUL_W-1:0] prod_pos;
  logic signed [MUL_W-1:0] prod_head;
  logic signed [POS_W+6:0] dpos;
  logic [HEAD_W-1:0]       dh;

  // saturating position update
  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] acc,
                                                      input logic signed [POS_W+6:0] d);
    logic signed [POS_W+7:0] s;
    s = (POS_W+8)'(acc) + (POS_W+8)'(d);
    if (s > POS_MAX) begin
      return POS_W'(POS_MAX);
    end else if (s < POS_MIN) begin
      return POS_W'(POS_MIN);
    end else begin
      return s[POS_W-1:0];
    end
  endfunction

  // old heading for the rotation, half of the new one for the quaternion
  assign cor_angle = cmd.cor_sel_new ? {1'b0, heading, 15'b0} : {heading, 16'b0};

  poi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cor_start),
    .angle   (cor_angle),
    .busy    (cor_busy),
    .done    (cor_done),
    .sin_q14 (sin_q14),
    .cos_q14 (cos_q14)
  );

  assign stat.cor_done = cor_done;
  assign stat.cor_busy = cor_busy;

  // shared multiplier operand selection
  always_comb begin
    unique case (cmd.mul_step)
      STEP_VXC: begin
        op_a = A_W'(vx);
        op_b = B_W'(cos_q14);
      end
      STEP_VYS: begin
        op_a = A_W'(vy);
        op_b = B_W'(sin_q14);
      end
      STEP_VXS: begin
        op_a = A_W'(vx);
        op_b = B_W'(sin_q14);
      end
      STEP_VYC: begin
        op_a = A_W'(vy);
        op_b = B_W'(cos_q14);
      end
      STEP_RXDT: begin
        op_a = A_W'(rx);
        op_b = B_W'({1'b0, dt});
      end
      STEP_RYDT: begin
        op_a = A_W'(ry);
        op_b = B_W'({1'b0, dt});
      end
      STEP_WZDT: begin
        op_a = A_W'(wz);
        op_b = B_W'({1'b0, dt});
      end
      STEP_WZK: begin
        op_a = prod[A_W-1:0];
        op_b = RAD_TO_TURN;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_next = MUL_W'(op_a) * MUL_W'(op_b);
  end

  // rounded position and heading increments from the product
  always_comb begin
    prod_pos  = prod + ROUND_POS;
    prod_head = prod + ROUND_HEAD;
    dpos      = prod_pos[MUL_W-1:26];
    dh        = prod_head[44+HEAD_W-1:44];
  end

  // item latch, product and rotated velocity
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vx <= vel_item.vel_x;
      vy <= vel_item.vel_y;
      wz <= vel_item.yaw_rate;
      dt <= vel_item.elapsed;
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.post_en) begin
      unique case (cmd.post_step)
        STEP_VXC: tmp <= prod[POS_W-1:0];
        STEP_VYS: rx  <= tmp - prod[POS_W-1:0];
        STEP_VXS: tmp <= prod[POS_W-1:0];
        STEP_VYC: ry  <= tmp + prod[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // pose accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x   <= '0;
      acc_y   <= '0;
      heading <= '0;
    end else if (cmd.post_en) begin
      unique case (cmd.post_step)
        STEP_RXDT: acc_x   <= sat_add(acc_x, dpos);
        STEP_RYDT: acc_y   <= sat_add(acc_y, dpos);
        STEP_WZK:  heading <= heading + dh;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pose_item.pos_x   <= acc_x;
      pose_item.pos_y   <= acc_y;
      pose_item.heading <= heading;
      pose_item.quat_z  <= sin_q14;
      pose_item.quat_w  <= cos_q14;
    end
  end

endmodule

`default_nettype wire

// ----- sv/poi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module poi_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           out_ready,
  input  wire poi_pkg::stat_t stat,
  output poi_pkg::cmd_t       cmd,
  output logic                in_ready,
  output logic                out_valid
);
  import poi_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START_A = 3'd1;
  localparam logic [2:0] S_WAIT_A  = 3'd2;
  localparam logic [2:0] S_MUL     = 3'd3;
  localparam logic [2:0] S_START_B = 3'd4;
  localparam logic [2:0] S_WAIT_B  = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  assign in_ready = (state == S_IDLE);

  // sequencing of the two cordic passes and the multiply chain
  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_START_A;
        end
      end
      S_START_A: begin
        cmd.cor_start = 1'b1;
        state_next    = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (stat.cor_done) begin
          step_next  = STEP_VXC;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en    = (step <= STEP_WZK);
        cmd.mul_step  = step;
        cmd.post_en   = (step != STEP_VXC);
        cmd.post_step = step - 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_START_B;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_START_B: begin
        cmd.cor_start   = 1'b1;
        cmd.cor_sel_new = 1'b1;
        state_next      = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (stat.cor_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result item handshake
  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/planar_odometry_integrator_core.sv -----
// Planar dead-reckoning integrator: each item on vel (body-frame velocity in Q4.12, yaw rate
// in Q4.12 rad/s, elapsed time in unsigned Q0.16 s) rotates the velocity by the heading held
// before the update, scales it by the elapsed time and adds it to a saturating Q16.16
// position, then advances the 16-bit binary-angle heading, which wraps once per turn. Each
// item yields exactly one pose item carrying the new position, heading and the yaw
// quaternion z = sin(h/2), w = cos(h/2) in Q1.14. One item is worked at a time: vel.ready
// rises again only once the item is through two passes of the single iterative CORDIC, one
// micro-rotation per cycle, and eight products on one shared multiplier. The finished
// pose sits in an output register, so the next item is taken while the previous pose still
// waits for pose.ready. Reset clears the position and heading to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_odometry_integrator_core_defines.svh"

module planar_odometry_integrator_core (
  input  wire logic  clk,
  input  wire logic  rst,
  poi_vel_if.sink    vel,
  poi_pose_if.source pose
);
  import poi_pkg::*;

  vel_t  vel_item;
  pose_t pose_item;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  // channel payload to and from the datapath
  assign vel_item.vel_x    = vel.vel_x;
  assign vel_item.vel_y    = vel.vel_y;
  assign vel_item.yaw_rate = vel.yaw_rate;
  assign vel_item.elapsed  = vel.elapsed;

  assign vel.ready    = in_ready;
  assign pose.valid   = out_valid;
  assign pose.pos_x   = pose_item.pos_x;
  assign pose.pos_y   = pose_item.pos_y;
  assign pose.heading = pose_item.heading;
  assign pose.quat_z  = pose_item.quat_z;
  assign pose.quat_w  = pose_item.quat_w;

  poi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vel.valid),
    .out_ready (pose.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  poi_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .vel_item  (vel_item),
    .cmd       (cmd),
    .stat      (stat),
    .pose_item (pose_item)
  );

  // a taken item keeps the block busy
  `POI_ASSERT_NXT(a_busy_after_accept, clk, rst, vel.valid && vel.ready, !vel.ready)
  // a waiting pose item is never overwritten
  `POI_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, !pose.valid || pose.ready)
  // cordic is only started when free
  `POI_ASSERT_IMP(a_cordic_free, clk, rst, cmd.cor_start, !stat.cor_busy)
  // multiplies read settled sine and cosine
  `POI_ASSERT_IMP(a_mul_after_cordic, clk, rst, cmd.mul_en, !stat.cor_busy)

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import poi_pkg::*;

  localparam int SWEEP_STEPS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_ITEMS  = 1525;
  // over this interval one unit of yaw rate turns the heading by exactly one unit
  localparam int UNIT_TURN_DT  = 25736;

  localparam longint GAIN_Q30 = 652032874;
  localparam longint RAD_TURN = 683565276;
  localparam longint ARC_TURN [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  poi_vel_if  vel_bus ();
  poi_pose_if pose_bus ();

  planar_odometry_integrator_core dut (
    .clk  (clk),
    .rst  (rst),
    .vel  (vel_bus),
    .pose (pose_bus)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted pose state
  int          pos_x_acc;
  int          pos_y_acc;
  logic [15:0] heading_acc;
  pose_t       pose_expected [$];

  int   fail_count  = 0;
  int   quiet_cycles = 0;
  bit   tx_idle_en  = 1'b0;
  bit   rx_idle_en  = 1'b0;
  bit   hold_toggle = 1'b0;
  bit   hold_seen   = 1'b0;
  int   stall_left  = 0;

  // gap length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic vel_t velocity_item(input int vx, input int vy, input int wz,
                                         input int dt);
    vel_t v;
    v.vel_x    = 16'(vx);
    v.vel_y    = 16'(vy);
    v.yaw_rate = 16'(wz);
    v.elapsed  = 16'(dt);
    return v;
  endfunction

  // q2.30 to q1.14 with rounding and clamp
  function automatic logic signed [15:0] round_q14(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return 16'(r);
  endfunction

  // rotation-mode cordic, angle in 2^32 units per turn
  task automatic cordic_sincos(input logic [31:0] angle, output logic signed [15:0] sin_q14,
                               output logic signed [15:0] cos_q14);
    longint z, x, y, xs, ys;
    bit     flip;
    int     i;
    z = {32'd0, angle};
    if (angle[31]) z = z - 64'sd4294967296;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    // fold into the right half plane
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1'b1;
    end
    for (i = 0; i < SWEEP_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARC_TURN[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ARC_TURN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q14 = round_q14(x);
    sin_q14 = round_q14(y);
  endtask

  function automatic int saturate32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // one update period: rotate by the old heading, integrate, then turn
  task automatic advance_pose(input vel_t v, output pose_t p);
    longint             vx, vy, wz, dt, c, s, rx, ry, dx, dy, dh;
    logic signed [15:0] sin_h, cos_h, qz, qw;
    vx = $signed(v.vel_x);
    vy = $signed(v.vel_y);
    wz = $signed(v.yaw_rate);
    dt = {48'd0, v.elapsed};
    cordic_sincos({heading_acc, 16'd0}, sin_h, cos_h);
    c  = cos_h;
    s  = sin_h;
    rx = vx * c - vy * s;
    ry = vx * s + vy * c;
    dx = (rx * dt + 64'sd33554432) >>> 26;
    dy = (ry * dt + 64'sd33554432) >>> 26;
    pos_x_acc = saturate32(longint'(pos_x_acc) + dx);
    pos_y_acc = saturate32(longint'(pos_y_acc) + dy);
    dh = (wz * dt * RAD_TURN + 64'sd8796093022208) >>> 44;
    heading_acc = heading_acc + dh[15:0];
    cordic_sincos({1'b0, heading_acc, 15'd0}, qz, qw);
    p.pos_x   = pos_x_acc;
    p.pos_y   = pos_y_acc;
    p.heading = heading_acc;
    p.quat_z  = qz;
    p.quat_w  = qw;
  endtask

  // offer one item and wait until it is taken
  task automatic send_velocity(input vel_t v);
    int    gap;
    pose_t p;
    gap = tx_idle_en ? idle_length() : 0;
    if (gap > 0) begin
      vel_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vel_bus.valid    <= 1'b1;
    vel_bus.vel_x    <= v.vel_x;
    vel_bus.vel_y    <= v.vel_y;
    vel_bus.yaw_rate <= v.yaw_rate;
    vel_bus.elapsed  <= v.elapsed;
    @(posedge clk);
    while (!vel_bus.ready) @(posedge clk);
    advance_pose(v, p);
    pose_expected.push_back(p);
  endtask

  // field extremes, zero elapsed time, quadrant boundaries and heading wrap
  task automatic test_directed_cases();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    send_velocity(velocity_item(0, 0, 0, 0));
    send_velocity(velocity_item(32767, 0, 0, 65535));
    send_velocity(velocity_item(-32768, 0, 0, 65535));
    send_velocity(velocity_item(0, 32767, 0, 65535));
    send_velocity(velocity_item(0, -32768, 0, 65535));
    send_velocity(velocity_item(100, -200, 0, 0));
    send_velocity(velocity_item(32767, 32767, 32767, 0));
    // step the heading onto and across each quarter turn
    send_velocity(velocity_item(32767, -32768, 16384, UNIT_TURN_DT));
    send_velocity(velocity_item(12000, -7000, 1, UNIT_TURN_DT));
    send_velocity(velocity_item(-5000, 9000, 16383, UNIT_TURN_DT));
    send_velocity(velocity_item(32767, 32767, 16384, UNIT_TURN_DT));
    send_velocity(velocity_item(-32768, -32768, 16383, UNIT_TURN_DT));
    send_velocity(velocity_item(1, 1, 1, UNIT_TURN_DT));
    send_velocity(velocity_item(300, -300, -1, UNIT_TURN_DT));
    send_velocity(velocity_item(32767, 32767, 32767, 65535));
    send_velocity(velocity_item(-32768, -32768, -32768, 65535));
    send_velocity(velocity_item(1, -1, -1, 1));
    send_velocity(velocity_item(0, 0, -32768, 1));
    send_velocity(velocity_item(-1, -1, 0, 65535));
  endtask

  // receiver holds off while items keep coming, so the input backs up
  task automatic test_output_backpressure();
    int n;
    tx_idle_en = 1'b0;
    hold_toggle <= ~hold_toggle;
    for (n = 0; n < 8; n++)
      send_velocity(velocity_item(int'($urandom_range(0, 16383)) - 8192,
                                  int'($urandom_range(0, 16383)) - 8192,
                                  int'($urandom_range(0, 4095)) - 2048,
                                  $urandom_range(1000, 4000)));
  endtask

  function automatic int extreme_value();
    case ($urandom_range(0, 5))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // mostly steady driving segments at update-rate timing, with noise and extremes mixed in
  task automatic test_random_drive();
    int   n, mode, seg_left, cruise_vx, cruise_vy, cruise_wz, dt;
    vel_t v;
    seg_left  = 0;
    cruise_vx = 0;
    cruise_vy = 0;
    cruise_wz = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en <= ($urandom_range(0, 3) != 0);
      end
      if (seg_left == 0) begin
        seg_left  = $urandom_range(20, 60);
        cruise_vx = int'($urandom_range(0, 16383)) - 8192;
        cruise_vy = int'($urandom_range(0, 2047)) - 1024;
        cruise_wz = int'($urandom_range(0, 8191)) - 4096;
      end
      seg_left = seg_left - 1;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        dt = 2185 + int'($urandom_range(0, 400)) - 200;
        v = velocity_item(cruise_vx + int'($urandom_range(0, 128)) - 64,
                          cruise_vy + int'($urandom_range(0, 128)) - 64,
                          cruise_wz + int'($urandom_range(0, 128)) - 64, dt);
      end else if (mode < 8) begin
        v = velocity_item($urandom, $urandom, $urandom, $urandom);
      end else if (mode == 8) begin
        v = velocity_item($urandom, $urandom, $urandom, 0);
      end else begin
        v = velocity_item(extreme_value(), extreme_value(), extreme_value(),
                          extreme_value());
      end
      send_velocity(v);
    end
  endtask

  // receiver: random stalls, plus the long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pose_bus.ready <= 1'b0;
      stall_left     <= 0;
      hold_seen      <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen      <= hold_toggle;
      stall_left     <= HOLD_CYCLES;
      pose_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      pose_bus.ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left     <= idle_length();
      pose_bus.ready <= 1'b0;
    end else begin
      pose_bus.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // compare each pose item with the oldest prediction
  always @(posedge clk) begin
    pose_t want;
    if (!rst && pose_bus.valid && pose_bus.ready) begin
      if (pose_expected.size() == 0) begin
        $error("pose item with no prediction waiting");
        fail_count++;
      end else begin
        want = pose_expected.pop_front();
        check_field("pos_x", want.pos_x, pose_bus.pos_x);
        check_field("pos_y", want.pos_y, pose_bus.pos_y);
        check_field("heading", want.heading, pose_bus.heading);
        check_field("quat_z", want.quat_z, pose_bus.quat_z);
        check_field("quat_w", want.quat_w, pose_bus.quat_w);
      end
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (rst || (vel_bus.valid && vel_bus.ready) || (pose_bus.valid && pose_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    vel_bus.valid    <= 1'b0;
    vel_bus.vel_x    <= '0;
    vel_bus.vel_y    <= '0;
    vel_bus.yaw_rate <= '0;
    vel_bus.elapsed  <= '0;
    pos_x_acc   = 0;
    pos_y_acc   = 0;
    heading_acc = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_random_drive();

    // drain
    vel_bus.valid <= 1'b0;
    while (pose_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
